/* sv/ics_pkg.sv */
// Package for the strided, padded 3x3 image convolution block.
// Holds sizes, field widths, register codes and the small-divisor helper.
// Depends on nothing; every other file imports it.
package ics_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int KERNEL_H   = 3;
    localparam int KERNEL_W   = 3;

    localparam int NUM_TAPS    = 9;
    localparam int PIX_W       = 16;
    localparam int PROD_W      = 2 * PIX_W;
    localparam int SUM_W       = 36;
    localparam int IDX_OUT_W   = 11;
    localparam int SIZE_W      = 11;
    localparam int STRIDE_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = ((DIM_W > SIZE_W) ? DIM_W : SIZE_W) + 1;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int BANK_W  = (KERNEL_H > 2) ? $clog2(KERNEL_H) : 1;

    localparam int RECIP_SH = 16;
    localparam int RECIP_3  = (2 ** RECIP_SH + 2) / 3;
    localparam int RECIP_5  = (2 ** RECIP_SH + 4) / 5;
    localparam int RECIP_6  = (2 ** RECIP_SH + 5) / 6;
    localparam int RECIP_7  = (2 ** RECIP_SH + 6) / 7;
    localparam int DP_W     = DIM_W + RECIP_SH;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TAPS_LO   = 3'd0,
        CFG_TAPS_HI   = 3'd1,
        CFG_TAP_NINTH = 3'd2,
        CFG_STRIDE    = 3'd3,
        CFG_PAD       = 3'd4,
        CFG_WIDTH     = 3'd5,
        CFG_HEIGHT    = 3'd6
    } cfg_index_t;

    // Quotient of x by a stride of one to seven, through a shift or a scaled reciprocal.
    function automatic logic [DIM_W-1:0] div_small(input logic [DIM_W-1:0] x,
                                                   input logic [STRIDE_W-1:0] s);
        logic [DP_W-1:0]  p;
        logic [DIM_W-1:0] q;
        p = '0;
        q = x;
        unique case (s)
            3'd2: q = x >> 1;
            3'd4: q = x >> 2;
            3'd3:
            begin
                p = DP_W'(x) * DP_W'(RECIP_3);
                q = p[DP_W-1:RECIP_SH];
            end
            3'd5:
            begin
                p = DP_W'(x) * DP_W'(RECIP_5);
                q = p[DP_W-1:RECIP_SH];
            end
            3'd6:
            begin
                p = DP_W'(x) * DP_W'(RECIP_6);
                q = p[DP_W-1:RECIP_SH];
            end
            3'd7:
            begin
                p = DP_W'(x) * DP_W'(RECIP_7);
                q = p[DP_W-1:RECIP_SH];
            end
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

/* sv/image_convolution_stride_pad.sv */
// Top level of the strided, padded 2-D convolution with line buffers.
// Depends on ics_pkg for sizes, register codes and the stride divider.
//
//   channel   handshake                  payload
//   pixel     pixel_valid / pixel_stall  pixel
//   result    result_valid/ result_stall conv_value, out_row, out_col, run_last, frame_last
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A pixel is taken every cycle while pixel_stall is low; a pixel that completes several
// windows holds the input while its further results are made, one after another, by
// the single shared row of nine multipliers. The first result of a pixel passes the s1,
// window, product and output registers in turn. After reset the line store is cleared
// one column per cycle, all MAX_WIDTH columns, with pixel_stall high. A stalled result
// freezes every stage past the first; a pixel may still enter an empty first stage.
module image_convolution_stride_pad
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       pixel_valid,
    output logic                                       pixel_stall,
    input  logic signed [ics_pkg::PIX_W-1:0]           pixel,
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output logic signed [ics_pkg::SUM_W-1:0]           conv_value,
    output logic        [ics_pkg::IDX_OUT_W-1:0]       out_row,
    output logic        [ics_pkg::IDX_OUT_W-1:0]       out_col,
    output logic                                       run_last,
    output logic                                       frame_last,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic        [ics_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic        [ics_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ics_pkg::*;

    logic signed [PIX_W-1:0]    tap_reg [NUM_TAPS];
    logic [STRIDE_W-1:0]        stride_reg;
    logic                       pad_reg;
    logic [SIZE_W-1:0]          width_reg;
    logic [SIZE_W-1:0]          height_reg;

    logic [DIM_W-1:0]           w_eff;
    logic [DIM_W-1:0]           h_eff;
    logic [STRIDE_W-1:0]        s_eff;
    logic [DIM_W-1:0]           xh;
    logic [DIM_W-1:0]           xw;
    logic [DIM_W-1:0]           qh_next;
    logic [DIM_W-1:0]           qw_next;
    logic [DIM_W-1:0]           dv_h_reg;
    logic [DIM_W-1:0]           dv_w_reg;
    logic [STRIDE_W-1:0]        dv_s_reg;
    logic                       dv_p_reg;
    logic [DIM_W-1:0]           dv_qh_reg;
    logic [DIM_W-1:0]           dv_qw_reg;
    logic                       dv_cr_reg;
    logic                       dv_cc_reg;

    logic [ROW_W-1:0]           row_reg;
    logic [COL_W-1:0]           col_reg;
    logic [BANK_W-1:0]          bank_reg;
    logic [ROW_W-1:0]           row_next;
    logic [COL_W-1:0]           col_next;
    logic [BANK_W-1:0]          bank_next;
    logic [ROW_W-1:0]           cur_r;
    logic [COL_W-1:0]           cur_c;
    logic [BANK_W-1:0]          cur_bank;

    logic                       clr_active_reg;
    logic [COL_W-1:0]           clr_cnt_reg;
    logic [PIX_W-1:0]           line_mem [KERNEL_H][MAX_WIDTH];
    logic signed [PIX_W-1:0]    rd_reg [KERNEL_H];

    logic                       acc;
    logic                       en;
    logic                       s1_move;
    logic                       s2_done;
    logic                       emit;

    logic                       s1_valid_reg;
    logic signed [PIX_W-1:0]    s1_pix_reg;
    logic [ROW_W-1:0]           s1_r_reg;
    logic [COL_W-1:0]           s1_c_reg;
    logic [BANK_W-1:0]          s1_bank_reg;
    logic                       re_next;
    logic                       rc_next;
    logic [DIM_W-1:0]           ridx_next;
    logic                       ce_next;
    logic                       cc_next;
    logic [DIM_W-1:0]           cidx_next;
    logic signed [PIX_W-1:0]    colvec [KERNEL_H];

    logic signed [PIX_W-1:0]    win_reg [KERNEL_H][KERNEL_W];
    logic                       s2_valid_reg;
    logic [COL_W-1:0]           s2_c_reg;
    logic                       s2_re_reg;
    logic                       s2_rc_reg;
    logic [DIM_W-1:0]           s2_ridx_reg;
    logic                       s2_ce_reg;
    logic                       s2_cc_reg;
    logic [DIM_W-1:0]           s2_cidx_reg;
    logic                       s2_ri_reg;
    logic                       s2_ci_reg;
    logic                       dr;
    logic                       dc;
    logic                       last_row;
    logic                       last_col;
    logic [DIM_W-1:0]           row_idx;
    logic [DIM_W-1:0]           col_idx;
    logic signed [PROD_W-1:0]   prod_next [KERNEL_H][KERNEL_W];

    logic                       s3_valid_reg;
    logic signed [PROD_W-1:0]   s3_prod_reg [KERNEL_H][KERNEL_W];
    logic [DIM_W-1:0]           s3_row_reg;
    logic [DIM_W-1:0]           s3_col_reg;
    logic                       s3_run_last_reg;
    logic                       s3_frame_last_reg;
    logic signed [SUM_W-1:0]    sum_next;

    logic                       out_valid_reg;
    logic signed [SUM_W-1:0]    conv_reg;
    logic [IDX_OUT_W-1:0]       out_row_reg;
    logic [IDX_OUT_W-1:0]       out_col_reg;
    logic                       run_last_reg;
    logic                       frame_last_reg;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [SIZE_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] d;
        if (v < SIZE_W'(3))
            d = DIM_W'(3);
        else if (CMP_W'(v) > CMP_W'(maxv))
            d = DIM_W'(maxv);
        else
            d = DIM_W'(v);
        return d;
    endfunction

    function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b);
        logic [BANK_W-1:0] n;
        if (CMP_W'(b) == CMP_W'(KERNEL_H - 1))
            n = '0;
        else
            n = b + BANK_W'(1);
        return n;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TAPS; t++)
                tap_reg[t] <= '0;
            stride_reg <= STRIDE_W'(1);
            pad_reg    <= 1'b1;
            width_reg  <= SIZE_W'(3);
            height_reg <= SIZE_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TAPS_LO:
                    for (int t = 0; t < 4; t++)
                        tap_reg[t] <= cfg_data[PIX_W*t +: PIX_W];
                CFG_TAPS_HI:
                    for (int t = 0; t < 4; t++)
                        tap_reg[t+4] <= cfg_data[PIX_W*t +: PIX_W];
                CFG_TAP_NINTH: tap_reg[8] <= cfg_data[PIX_W-1:0];
                CFG_STRIDE:    stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_PAD:       pad_reg <= cfg_data[0];
                CFG_WIDTH:     width_reg <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:    height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_eff   = eff_dim(width_reg, MAX_WIDTH);
        h_eff   = eff_dim(height_reg, MAX_HEIGHT);
        s_eff   = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
        xh      = h_eff - DIM_W'(KERNEL_H) + DIM_W'({pad_reg, 1'b0});
        xw      = w_eff - DIM_W'(KERNEL_W) + DIM_W'({pad_reg, 1'b0});
        qh_next = div_small(xh, s_eff);
        qw_next = div_small(xw, s_eff);
    end

    always_ff @(posedge clk)
    begin
        dv_h_reg  <= h_eff;
        dv_w_reg  <= w_eff;
        dv_s_reg  <= s_eff;
        dv_p_reg  <= pad_reg;
        dv_qh_reg <= qh_next;
        dv_qw_reg <= qw_next;
        dv_cr_reg <= pad_reg &&
                     ((DIM_W+STRIDE_W)'(qh_next) * (DIM_W+STRIDE_W)'(s_eff) ==
                      (DIM_W+STRIDE_W)'(xh));
        dv_cc_reg <= pad_reg &&
                     ((DIM_W+STRIDE_W)'(qw_next) * (DIM_W+STRIDE_W)'(s_eff) ==
                      (DIM_W+STRIDE_W)'(xw));
    end

    always_comb
    begin
        cur_r    = row_reg;
        cur_c    = col_reg;
        cur_bank = bank_reg;
        if (CMP_W'(col_reg) >= CMP_W'(w_eff))
        begin
            cur_c    = '0;
            cur_r    = row_reg + ROW_W'(1);
            cur_bank = bank_inc(bank_reg);
        end
        if (CMP_W'(row_reg) + CMP_W'(CMP_W'(col_reg) >= CMP_W'(w_eff)) >= CMP_W'(h_eff))
        begin
            cur_r    = '0;
            cur_bank = '0;
        end
        row_next  = cur_r;
        col_next  = cur_c + COL_W'(1);
        bank_next = cur_bank;
        if (CMP_W'(cur_c) + CMP_W'(1) >= CMP_W'(w_eff))
        begin
            col_next  = '0;
            row_next  = cur_r + ROW_W'(1);
            bank_next = bank_inc(cur_bank);
            if (CMP_W'(cur_r) + CMP_W'(1) >= CMP_W'(h_eff))
            begin
                row_next  = '0;
                bank_next = '0;
            end
        end
    end

    assign en          = !out_valid_reg || !result_stall;
    assign s1_move     = s1_valid_reg && en && (!s2_valid_reg || s2_done);
    assign pixel_stall = clr_active_reg || (s1_valid_reg && !s1_move);
    assign acc         = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            bank_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (acc)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                bank_reg <= bank_next;
            end
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
                if (clr_cnt_reg == COL_W'(MAX_WIDTH - 1))
                    clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < KERNEL_H; b++)
        begin
            if (clr_active_reg)
                line_mem[b][clr_cnt_reg] <= '0;
            else if (acc && (cur_bank == BANK_W'(b)))
                line_mem[b][cur_c] <= pixel;
            if (acc)
                rd_reg[b] <= line_mem[b][cur_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg  <= pixel;
            s1_r_reg    <= cur_r;
            s1_c_reg    <= cur_c;
            s1_bank_reg <= cur_bank;
        end
    end

    always_comb
    begin
        logic [DIM_W:0]          xr;
        logic [DIM_W:0]          xc;
        logic [DIM_W-1:0]        qr;
        logic [DIM_W-1:0]        qc;
        int                      bi;
        xr = (DIM_W+1)'(s1_r_reg) + (DIM_W+1)'(dv_p_reg) - (DIM_W+1)'(KERNEL_H - 1);
        xc = (DIM_W+1)'(s1_c_reg) + (DIM_W+1)'(dv_p_reg) - (DIM_W+1)'(KERNEL_W - 1);
        qr = div_small(xr[DIM_W-1:0], dv_s_reg);
        qc = div_small(xc[DIM_W-1:0], dv_s_reg);
        re_next   = !xr[DIM_W] && ((DIM_W+STRIDE_W)'(qr) * (DIM_W+STRIDE_W)'(dv_s_reg) ==
                                   (DIM_W+STRIDE_W)'(xr[DIM_W-1:0]));
        ce_next   = !xc[DIM_W] && ((DIM_W+STRIDE_W)'(qc) * (DIM_W+STRIDE_W)'(dv_s_reg) ==
                                   (DIM_W+STRIDE_W)'(xc[DIM_W-1:0]));
        ridx_next = qr;
        cidx_next = qc;
        rc_next   = dv_cr_reg && (CMP_W'(s1_r_reg) + CMP_W'(1) == CMP_W'(dv_h_reg));
        cc_next   = dv_cc_reg && (CMP_W'(s1_c_reg) + CMP_W'(1) == CMP_W'(dv_w_reg));
        for (int l = 0; l < KERNEL_H; l++)
        begin
            bi = int'(s1_bank_reg) + KERNEL_H - (KERNEL_H - 1 - l);
            if (bi >= KERNEL_H)
                bi = bi - KERNEL_H;
            if (l == KERNEL_H - 1)
                colvec[l] = s1_pix_reg;
            else if (CMP_W'(s1_r_reg) < CMP_W'(KERNEL_H - 1 - l))
                colvec[l] = '0;
            else
                colvec[l] = rd_reg[bi];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int l = 0; l < KERNEL_H; l++)
            begin
                for (int m = 0; m < KERNEL_W - 1; m++)
                    win_reg[l][m] <= win_reg[l][m+1];
                win_reg[l][KERNEL_W-1] <= colvec[l];
            end
            s2_c_reg    <= s1_c_reg;
            s2_re_reg   <= re_next;
            s2_rc_reg   <= rc_next;
            s2_ridx_reg <= ridx_next;
            s2_ce_reg   <= ce_next;
            s2_cc_reg   <= cc_next;
            s2_cidx_reg <= cidx_next;
        end
    end

    always_comb
    begin
        int lp;
        int mp;
        logic signed [PIX_W-1:0] pv;
        dr       = s2_ri_reg || !s2_re_reg;
        dc       = s2_ci_reg || !s2_ce_reg;
        row_idx  = dr ? dv_qh_reg : s2_ridx_reg;
        col_idx  = dc ? dv_qw_reg : s2_cidx_reg;
        last_row = s2_ri_reg || !(s2_re_reg && s2_rc_reg);
        last_col = s2_ci_reg || !(s2_ce_reg && s2_cc_reg);
        s2_done  = s2_valid_reg &&
                   (!((s2_re_reg || s2_rc_reg) && (s2_ce_reg || s2_cc_reg)) ||
                    (last_row && last_col));
        emit     = en && s2_valid_reg && (s2_re_reg || s2_rc_reg) && (s2_ce_reg || s2_cc_reg);
        for (int l = 0; l < KERNEL_H; l++)
        begin
            for (int m = 0; m < KERNEL_W; m++)
            begin
                lp = l + int'(dr);
                mp = m + int'(dc);
                pv = '0;
                if (lp < KERNEL_H && mp < KERNEL_W && (int'(s2_c_reg) + mp >= KERNEL_W - 1))
                    pv = win_reg[lp][mp];
                prod_next[l][m] = PROD_W'(pv) * PROD_W'(tap_reg[l*KERNEL_W+m]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_ri_reg     <= 1'b0;
            s2_ci_reg     <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
                s2_ri_reg    <= 1'b0;
                s2_ci_reg    <= 1'b0;
            end
            else if (en && s2_done)
                s2_valid_reg <= 1'b0;
            else if (emit)
            begin
                if (last_col)
                begin
                    s2_ci_reg <= 1'b0;
                    s2_ri_reg <= 1'b1;
                end
                else
                    s2_ci_reg <= 1'b1;
            end

            if (en)
            begin
                s3_valid_reg  <= emit;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_prod_reg       <= prod_next;
            s3_row_reg        <= row_idx;
            s3_col_reg        <= col_idx;
            s3_run_last_reg   <= last_row && last_col;
            s3_frame_last_reg <= (row_idx == dv_qh_reg) && (col_idx == dv_qw_reg);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int l = 0; l < KERNEL_H; l++)
            for (int m = 0; m < KERNEL_W; m++)
                sum_next = sum_next + SUM_W'(s3_prod_reg[l][m]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            conv_reg       <= sum_next;
            out_row_reg    <= IDX_OUT_W'(s3_row_reg);
            out_col_reg    <= IDX_OUT_W'(s3_col_reg);
            run_last_reg   <= s3_run_last_reg;
            frame_last_reg <= s3_frame_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign conv_value   = conv_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign run_last     = run_last_reg;
    assign frame_last   = frame_last_reg;

endmodule

/* sv/ics_checker.sv */
// Port-level checker for the convolution block, attached by a bind statement.
// Depends on ics_pkg for port widths.
module ics_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   result_valid,
    input logic                                   result_stall,
    input logic signed [ics_pkg::SUM_W-1:0]       conv_value,
    input logic        [ics_pkg::IDX_OUT_W-1:0]   out_row,
    input logic        [ics_pkg::IDX_OUT_W-1:0]   out_col,
    input logic                                   run_last,
    input logic                                   frame_last
);
    import ics_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result request dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(conv_value) && $stable(out_row) &&
            $stable(out_col) && $stable(run_last) && $stable(frame_last))
        else $error("result payload changed while stalled");

    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_last |-> run_last)
        else $error("frame end is not the last result of its pixel");

    a_run_is_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !run_last |=> result_valid)
        else $error("gap inside the results of one pixel");

endmodule

bind image_convolution_stride_pad ics_checker u_ics_checker (.*);

/* tb/image_convolution_stride_pad_checker.sv */
// Result checker for the strided, padded 3x3 image convolution block.
// Watches the pixel, result and config channels, predicts every output window sum
// and compares it field by field. Depends on ics_pkg for widths and register codes.
`timescale 1ns / 1ps

module image_convolution_stride_pad_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    input  logic                                   pixel_stall,
    input  logic signed [ics_pkg::PIX_W-1:0]       pixel,
    input  logic                                   result_valid,
    input  logic                                   result_stall,
    input  logic signed [ics_pkg::SUM_W-1:0]       conv_value,
    input  logic        [ics_pkg::IDX_OUT_W-1:0]   out_row,
    input  logic        [ics_pkg::IDX_OUT_W-1:0]   out_col,
    input  logic                                   run_last,
    input  logic                                   frame_last,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic        [ics_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [ics_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                     errors,
    output int                                     pending
);
    import ics_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0]     sum;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 run_end;
        logic                 frame_end;
    } window_result_t;

    window_result_t     window_q[$];
    logic [63:0]        taps_lo;
    logic [63:0]        taps_hi;
    logic [15:0]        tap_last;
    logic [STRIDE_W-1:0] stride_reg;
    logic               pad_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [PIX_W-1:0]   rows_kept[KERNEL_H][MAX_WIDTH];
    int                 row_at;
    int                 col_at;

    function automatic int clamp_dim(int v, int maxv);
        if (v < 3)
            return 3;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int last_covered(int o, int s, int k, int p, int dim);
        int v;
        v = o * s + k - 1 - p;
        return (v > dim - 1) ? dim - 1 : v;
    endfunction

    function automatic longint tap_value(int k);
        logic signed [15:0] t;
        if (k < 4)
            t = taps_lo[16*k +: 16];
        else if (k < 8)
            t = taps_hi[16*(k-4) +: 16];
        else
            t = tap_last;
        return longint'(t);
    endfunction

    function automatic longint kept_pixel(int r, int c, int h, int w);
        logic signed [15:0] v;
        if (r < 0 || c < 0 || r >= h || c >= w || c >= MAX_WIDTH)
            return 0;
        v = rows_kept[r % KERNEL_H][c];
        return longint'(v);
    endfunction

    task automatic predict_windows(input logic [PIX_W-1:0] value);
        int w, h, s, p, out_h, out_w, r, c, nr, nc;
        int hit_rows[2];
        int hit_cols[2];
        longint acc;
        window_result_t res;
        w = clamp_dim(int'(width_reg), MAX_WIDTH);
        h = clamp_dim(int'(height_reg), MAX_HEIGHT);
        s = (stride_reg == 0) ? 1 : int'(stride_reg);
        p = pad_reg ? 1 : 0;
        out_h = (h - KERNEL_H + 2 * p) / s + 1;
        out_w = (w - KERNEL_W + 2 * p) / s + 1;
        nr = 0;
        nc = 0;
        if (col_at >= w)
        begin
            col_at = 0;
            row_at++;
        end
        if (row_at >= h)
            row_at = 0;
        r = row_at;
        c = col_at;
        rows_kept[r % KERNEL_H][c] = value;
        for (int i = 0; i < out_h && nr < 2; i++)
            if (last_covered(i, s, KERNEL_H, p, h) == r)
                hit_rows[nr++] = i;
        for (int j = 0; j < out_w && nc < 2; j++)
            if (last_covered(j, s, KERNEL_W, p, w) == c)
                hit_cols[nc++] = j;
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
            begin
                acc = 0;
                for (int l = 0; l < KERNEL_H; l++)
                    for (int m = 0; m < KERNEL_W; m++)
                        acc += tap_value(l * KERNEL_W + m) *
                               kept_pixel(hit_rows[i] * s - p + l,
                                          hit_cols[j] * s - p + m, h, w);
                res.sum       = acc[SUM_W-1:0];
                res.row       = hit_rows[i][IDX_OUT_W-1:0];
                res.col       = hit_cols[j][IDX_OUT_W-1:0];
                res.run_end   = (i == nr - 1 && j == nc - 1);
                res.frame_end = (hit_rows[i] == out_h - 1 && hit_cols[j] == out_w - 1);
                window_q.push_back(res);
            end
        col_at++;
        if (col_at >= w)
        begin
            col_at = 0;
            row_at++;
            if (row_at >= h)
                row_at = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;
        if (!rst_n)
        begin
            taps_lo    = '0;
            taps_hi    = '0;
            tap_last   = '0;
            stride_reg = 3'd1;
            pad_reg    = 1'b1;
            width_reg  = 11'd3;
            height_reg = 11'd3;
            row_at     = 0;
            col_at     = 0;
            for (int i = 0; i < KERNEL_H; i++)
                for (int j = 0; j < MAX_WIDTH; j++)
                    rows_kept[i][j] = '0;
            window_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (window_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%t: unexpected result row %0d col %0d value %0d",
                                 $realtime, out_row, out_col, conv_value);
                    errors++;
                end
                else
                begin
                    want = window_q.pop_front();
                    if (want.sum !== conv_value || want.row !== out_row ||
                        want.col !== out_col || want.run_end !== run_last ||
                        want.frame_end !== frame_last)
                    begin
                        if (errors < 10)
                            $display("%t: mismatch expected %0d r%0d c%0d rl%0b fl%0b, got %0d r%0d c%0d rl%0b fl%0b",
                                     $realtime, $signed(want.sum), want.row, want.col,
                                     want.run_end, want.frame_end, conv_value, out_row,
                                     out_col, run_last, frame_last);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TAPS_LO:   taps_lo    = cfg_data;
                    CFG_TAPS_HI:   taps_hi    = cfg_data;
                    CFG_TAP_NINTH: tap_last   = cfg_data[15:0];
                    CFG_STRIDE:    stride_reg = cfg_data[STRIDE_W-1:0];
                    CFG_PAD:       pad_reg    = cfg_data[0];
                    CFG_WIDTH:     width_reg  = cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:    height_reg = cfg_data[SIZE_W-1:0];
                    default:       ;
                endcase
            end
            if (pixel_valid && !pixel_stall)
                predict_windows(pixel);
            pending = window_q.size();
        end
    end

endmodule

/* tb/image_convolution_stride_pad_tb.sv */
// Top of the testbench for the strided, padded 3x3 image convolution block.
// Drives pixel frames and register settings with random gaps and stalls, and
// gives the verdict from the checker's counts. Depends on ics_pkg and the checker.
`timescale 1ns / 1ps

module image_convolution_stride_pad_tb;
    import ics_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic                         clk;
    logic                         rst_n;
    logic                         pixel_valid;
    logic                         pixel_stall;
    logic signed [PIX_W-1:0]      pixel;
    logic                         result_valid;
    logic                         result_stall;
    logic signed [SUM_W-1:0]      conv_value;
    logic        [IDX_OUT_W-1:0]  out_row;
    logic        [IDX_OUT_W-1:0]  out_col;
    logic                         run_last;
    logic                         frame_last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic        [CFG_INDEX_W-1:0] cfg_index;
    logic        [CFG_DATA_W-1:0]  cfg_data;
    int                           errors;
    int                           pending;
    int                           idle_cycles = 0;
    int                           pixels_sent;
    bit                           hold_request;
    bit                           no_gaps;

    image_convolution_stride_pad u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .conv_value   (conv_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .run_last     (run_last),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    image_convolution_stride_pad_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .conv_value   (conv_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .run_last     (run_last),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    function automatic int clamp_count(int v);
        return (v < 3) ? 3 : v;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= value;
        do
            @(posedge clk);
        while (pixel_stall);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        pixel_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic run_setting(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] ninth, input logic [2:0] stride,
                               input logic pad, input logic [10:0] w,
                               input logic [10:0] h, input int count, input bit fixed,
                               input logic [PIX_W-1:0] value);
        drain_results();
        write_reg(CFG_TAPS_LO, lo);
        write_reg(CFG_TAPS_HI, hi);
        write_reg(CFG_TAP_NINTH, {48'd0, ninth});
        write_reg(CFG_STRIDE, {61'd0, stride});
        write_reg(CFG_PAD, {63'd0, pad});
        write_reg(CFG_WIDTH, {53'd0, w});
        write_reg(CFG_HEIGHT, {53'd0, h});
        for (int i = 0; i < count; i++)
            send_pixel(fixed ? value : pick_pixel());
    endtask

    initial
    begin
        int holds_done;
        holds_done   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && holds_done == 0)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
                holds_done = 1;
            end
            else if (pick_gap() > 0)
            begin
                result_stall <= 1'b1;
                repeat (pick_gap() + 1) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("image_convolution_stride_pad test failed");
            $finish;
        end
    end

    initial
    begin
        int w, h, n;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TAPS_LO;
        cfg_data     = '0;
        pixels_sent  = 0;
        hold_request = 1'b0;
        no_gaps      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        run_setting({4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF, 3'd1, 1'b1, 11'd3, 11'd3,
                    9, 1'b1, 16'h8000);
        run_setting({4{16'h8000}}, {4{16'h8000}}, 16'h8000, 3'd0, 1'b0, 11'd1, 11'd2,
                    9, 1'b1, 16'h8000);
        run_setting({4{16'h0100}}, {4{16'hFF00}}, 16'h0100, 3'd2, 1'b1, 11'd4, 11'd4,
                    5, 1'b0, '0);
        run_setting({4{16'h0100}}, {4{16'hFF00}}, 16'h0100, 3'd2, 1'b1, 11'd3, 11'd4,
                    4, 1'b0, '0);

        no_gaps = 1'b1;
        hold_request = 1'b1;
        run_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()),
                    3'd1, 1'b1, 11'd6, 11'd6, 36, 1'b0, '0);
        no_gaps = 1'b0;

        while (pixels_sent < 120)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            n = clamp_count(w) * clamp_count(h);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            run_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()),
                        3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 11'(w), 11'(h),
                        n, 1'b0, '0);
        end
        no_gaps = 1'b0;

        run_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()),
                    3'd7, 1'b1, 11'd2047, 11'd3, 12, 1'b0, '0);
        run_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()),
                    3'd5, 1'b0, 11'd3, 11'd2047, 24, 1'b0, '0);
        run_setting({4{16'h7FFF}}, {4{16'h8000}}, 16'h7FFF, 3'd4, 1'b1, 11'd5, 11'd5,
                    25, 1'b0, '0);

        drain_results();
        if (errors == 0 && pending == 0)
            $display("image_convolution_stride_pad test passed");
        else
            $display("image_convolution_stride_pad test failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/ics_pkg.sv
sv/image_convolution_stride_pad.sv
sv/ics_checker.sv
tb/image_convolution_stride_pad_checker.sv
tb/image_convolution_stride_pad_tb.sv
